// ----- rtl/hcio_pkg.sv -----
// ----------------------------------------------------------------------------
// hcio_pkg
// Shared types and constants of the home computer I/O port unit: event
// codes, field widths, frame timing and the reciprocal used for sample
// index scaling.
// ----------------------------------------------------------------------------
package hcio_pkg;

    // Frame timing
    localparam int TSTATES_FRAME = 69888;   // 1000 .. 131071
    localparam int SAMPLES_FRAME = 1024;    // 1 .. 2047

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int PORT_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 17;
    localparam int SAMPLE_W = 11;
    localparam int BORDER_W = 3;
    localparam int FRAME_W  = 5;

    // Key matrix geometry
    localparam int KEY_ROWS = 8;
    localparam int KEY_COLS = 5;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;

    // Event codes
    typedef enum logic [OP_W-1:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_KEY   = 3'd2,
        OP_JOY   = 3'd3,
        OP_FRAME = 3'd4
    } op_t;

    // Byte constants
    localparam logic [BYTE_W-1:0]   BYTE_ONES    = 8'hFF;
    localparam logic [BYTE_W-1:0]   KEY_FILL     = 8'hE0;
    localparam logic [BYTE_W-1:0]   JOY_PORT_LO  = 8'h1F;
    localparam logic [BYTE_W-1:0]   LEVEL_HIGH   = 8'd200;
    localparam logic [BYTE_W-1:0]   LEVEL_LOW    = 8'd56;
    localparam logic [BORDER_W-1:0] BORDER_RESET = 3'd7;
    localparam logic [KEY_COLS-1:0] ROW_IDLE     = '1;

    localparam logic [TIME_W-1:0]   TIME_LIMIT   = TIME_W'(TSTATES_FRAME);
    localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT = SAMPLE_W'(SAMPLES_FRAME);

    // t * SAMPLES_FRAME / TSTATES_FRAME as a multiply by a rounded-up
    // reciprocal. With t saturated to the frame length, x = t * SAMPLES_FRAME
    // stays below 2^SCALED_W and x * TSTATES_FRAME below 2^RECIP_SHIFT, which
    // makes the truncated product exact.
    localparam int SCALED_W    = $clog2(TSTATES_FRAME * SAMPLES_FRAME + 1);
    localparam int RECIP_SHIFT = SCALED_W + $clog2(TSTATES_FRAME + 1);
    localparam longint unsigned RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) + 64'(TSTATES_FRAME) - 64'd1) / 64'(TSTATES_FRAME);
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int PROD_W      = SCALED_W + RECIP_W;

endpackage

// ----- rtl/home_computer_io_port_unit.sv -----
// ----------------------------------------------------------------------------
// home_computer_io_port_unit
// Keyboard matrix, joystick port, border register and event-driven beeper
// of a small home computer, one event per beat.
// ----------------------------------------------------------------------------
// Every event beat (port read, port write, key change, joystick load or frame
// end) yields exactly one result beat. The unit takes one event per cycle
// while in_stall is low; each event passes through an input register and a
// result register, and the result beat is offered from the result register
// once the event has moved on from the input register.
// The per-event work sits between those two registers: the key row
// AND, the port decode and the time-to-sample scaling, whose one
// reciprocal multiply sets the critical path. The output register decouples
// the two sides, so a new event is still taken while a result waits, and
// in_stall rises only when both registers hold a beat and the output is
// stalled.
// ----------------------------------------------------------------------------
module home_computer_io_port_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // event channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hcio_pkg::OP_W-1:0]         opcode,
    input  logic [hcio_pkg::PORT_W-1:0]       port,
    input  logic [hcio_pkg::BYTE_W-1:0]       data,
    input  logic [hcio_pkg::ROW_W-1:0]        key_row,
    input  logic [hcio_pkg::COL_W-1:0]        key_column,
    input  logic                              key_pressed,
    input  logic [hcio_pkg::TIME_W-1:0]       frame_time,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hcio_pkg::BYTE_W-1:0]       read_data,
    output logic [hcio_pkg::BORDER_W-1:0]     border_colour,
    output logic                              audio_valid,
    output logic [hcio_pkg::SAMPLE_W-1:0]     audio_first,
    output logic [hcio_pkg::SAMPLE_W-1:0]     audio_end,
    output logic [hcio_pkg::BYTE_W-1:0]       audio_level,
    output logic                              flash_phase
);
    import hcio_pkg::*;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic res_valid_reg, res_valid_next;
    logic in_accept;
    logic advance;      // result register free this cycle
    logic fire;         // event in stage 1 is processed this cycle

    // Stage 1 payload
    logic [OP_W-1:0]   op_reg;
    logic [PORT_W-1:0] port_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              pressed_reg;
    logic [TIME_W-1:0] time_reg;

    // Machine state
    logic [KEY_COLS-1:0] key_rows_reg  [KEY_ROWS];
    logic [KEY_COLS-1:0] key_rows_next [KEY_ROWS];
    logic [BYTE_W-1:0]   joy_reg, joy_next;
    logic [BORDER_W-1:0] border_reg, border_next;
    logic                beeper_reg, beeper_next;
    // the edge time only ever feeds the sample scaling, so its sample
    // index is kept instead
    logic [SAMPLE_W-1:0] last_sample_reg, last_sample_next;
    logic [FRAME_W-1:0]  frame_cnt_reg, frame_cnt_next;

    // Result register
    logic [BYTE_W-1:0]   rd_reg, rd_next;
    logic [BORDER_W-1:0] res_border_reg;
    logic                aud_valid_reg, aud_valid_next;
    logic [SAMPLE_W-1:0] aud_first_reg, aud_first_next;
    logic [SAMPLE_W-1:0] aud_end_reg, aud_end_next;
    logic [BYTE_W-1:0]   aud_level_reg, aud_level_next;
    logic                flash_reg;

    // Datapath
    logic [TIME_W-1:0]   time_sat;
    logic [SAMPLE_W-1:0] write_sample;
    logic [SAMPLE_W-1:0] run_end;
    logic                run_open;
    logic                run_ok;
    logic [KEY_COLS-1:0] key_and;
    logic                even_port;

    assign advance   = !res_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign fire      = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sample scaling of a write time, saturated to the frame length
    // ------------------------------------------------------------------
    assign time_sat = (time_reg > TIME_LIMIT) ? TIME_LIMIT : time_reg;

    hcio_sample_calc u_sample_calc (
        .frame_t    (time_sat),
        .sample_idx (write_sample)
    );

    assign even_port = !port_reg[0];

    // A frame end always runs to the last sample of the frame.
    assign run_end = (op_reg == OP_FRAME) ? SAMPLE_LIMIT : write_sample;
    assign run_ok  = last_sample_reg < run_end;

    // AND of the rows selected by a low high-address bit
    always_comb
    begin
        key_and = ROW_IDLE;
        for (int i = 0; i < KEY_ROWS; i++)
        begin
            if (!port_reg[BYTE_W + i])
            begin
                key_and = key_and & key_rows_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Event decode: next state and result
    // ------------------------------------------------------------------
    always_comb
    begin
        key_rows_next    = key_rows_reg;
        joy_next         = joy_reg;
        border_next      = border_reg;
        beeper_next      = beeper_reg;
        last_sample_next = last_sample_reg;
        frame_cnt_next   = frame_cnt_reg;
        rd_next          = BYTE_ONES;
        run_open         = 1'b0;

        case (op_reg)
            OP_READ:
            begin
                if (even_port)
                begin
                    rd_next = BYTE_W'(key_and) | KEY_FILL;
                end
                else if (port_reg[BYTE_W-1:0] == JOY_PORT_LO)
                begin
                    rd_next = joy_reg;
                end
            end
            OP_WRITE:
            begin
                if (even_port)
                begin
                    border_next      = data_reg[BORDER_W-1:0];
                    beeper_next      = data_reg[4];
                    run_open         = 1'b1;
                    last_sample_next = write_sample;
                end
            end
            OP_KEY:
            begin
                if (col_reg < COL_W'(KEY_COLS))
                begin
                    key_rows_next[row_reg][col_reg] = !pressed_reg;
                end
            end
            OP_JOY:
            begin
                joy_next = data_reg;
            end
            OP_FRAME:
            begin
                run_open         = 1'b1;
                last_sample_next = '0;
                frame_cnt_next   = frame_cnt_reg + FRAME_W'(1);
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase

        // the run carries the beeper level from before this event
        aud_valid_next = run_open && run_ok;
        aud_first_next = aud_valid_next ? last_sample_reg : '0;
        aud_end_next   = aud_valid_next ? run_end : '0;
        aud_level_next = !aud_valid_next ? '0 : (beeper_reg ? LEVEL_HIGH : LEVEL_LOW);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            for (int i = 0; i < KEY_ROWS; i++)
            begin
                key_rows_reg[i] <= ROW_IDLE;
            end
            joy_reg         <= '0;
            border_reg      <= BORDER_RESET;
            beeper_reg      <= 1'b0;
            last_sample_reg <= '0;
            frame_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                key_rows_reg    <= key_rows_next;
                joy_reg         <= joy_next;
                border_reg      <= border_next;
                beeper_reg      <= beeper_next;
                last_sample_reg <= last_sample_next;
                frame_cnt_reg   <= frame_cnt_next;
            end
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= opcode;
            port_reg    <= port;
            data_reg    <= data;
            row_reg     <= key_row;
            col_reg     <= key_column;
            pressed_reg <= key_pressed;
            time_reg    <= frame_time;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg         <= rd_next;
            res_border_reg <= border_next;
            aud_valid_reg  <= aud_valid_next;
            aud_first_reg  <= aud_first_next;
            aud_end_reg    <= aud_end_next;
            aud_level_reg  <= aud_level_next;
            flash_reg      <= frame_cnt_next[FRAME_W-1];
        end
    end

    assign out_valid     = res_valid_reg;
    assign read_data     = rd_reg;
    assign border_colour = res_border_reg;
    assign audio_valid   = aud_valid_reg;
    assign audio_first   = aud_first_reg;
    assign audio_end     = aud_end_reg;
    assign audio_level   = aud_level_reg;
    assign flash_phase   = flash_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // back-pressure only when both stages are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && res_valid_reg))
        else $error("in_stall without both stages full");

    // an emitted run is never empty and never passes the frame end
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && audio_valid) |->
            ((audio_first < audio_end) && (audio_end <= SAMPLE_LIMIT)))
        else $error("audio run out of order");

    // an emitted run carries one of the two beeper levels
    a_run_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && audio_valid) |->
            ((audio_level == LEVEL_HIGH) || (audio_level == LEVEL_LOW)))
        else $error("audio level not a beeper level");

    // no run: all run fields are zero
    a_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !audio_valid) |->
            ((audio_first == '0) && (audio_end == '0) && (audio_level == '0)))
        else $error("run fields set without a run");

endmodule

// ----- rtl/hcio_sample_calc.sv -----
// ----------------------------------------------------------------------------
// hcio_sample_calc
// Maps a saturated T-state time onto a sample index within the frame,
// rounded down and clamped to the samples per frame.
// ----------------------------------------------------------------------------
module hcio_sample_calc (
    input  logic [hcio_pkg::TIME_W-1:0]   frame_t,
    output logic [hcio_pkg::SAMPLE_W-1:0] sample_idx
);
    import hcio_pkg::*;

    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] quot;

    // constant scale, then one multiply by the reciprocal
    assign scaled = SCALED_W'(frame_t) * SCALED_W'(SAMPLES_FRAME);
    assign prod   = PROD_W'(scaled) * PROD_W'(RECIP_MULT);
    assign quot   = SAMPLE_W'(prod >> RECIP_SHIFT);

    assign sample_idx = (quot > SAMPLE_LIMIT) ? SAMPLE_LIMIT : quot;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I/O port unit. Every event beat is mirrored
// in a behavioural copy of the key matrix, joystick latch, border and beeper.
// The expected result beats are queued in order and checked field by field
// as they leave the block. A short directed pass comes first. Random frame
// sequences with noise mixed in follow, with bursty input and a shifting
// output stall pattern.
// ----------------------------------------------------------------------------
module tb_top;
    import hcio_pkg::*;

    localparam int unsigned CLK_HIGH       = 10;
    localparam int unsigned CLK_LOW        = 10;
    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned RANDOM_ITEMS   = 1100;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;     // two-stage pipe plus margin

    // opcodes beyond the defined set: the block must leave all state alone
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // write byte layout: bits 2..0 border, bit 4 beeper
    localparam int BEEP_BIT = 4;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_data;
        logic [BORDER_W-1:0] border_colour;
        logic                audio_valid;
        logic [SAMPLE_W-1:0] audio_first;
        logic [SAMPLE_W-1:0] audio_end;
        logic [BYTE_W-1:0]   audio_level;
        logic                flash_phase;
    } port_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts from a known value
    // ------------------------------------------------------------------
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode      = '0;
    logic [PORT_W-1:0]   port        = '0;
    logic [BYTE_W-1:0]   data        = '0;
    logic [ROW_W-1:0]    key_row     = '0;
    logic [COL_W-1:0]    key_column  = '0;
    logic                key_pressed = 1'b0;
    logic [TIME_W-1:0]   frame_time  = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [BYTE_W-1:0]   read_data;
    logic [BORDER_W-1:0] border_colour;
    logic                audio_valid;
    logic [SAMPLE_W-1:0] audio_first;
    logic [SAMPLE_W-1:0] audio_end;
    logic [BYTE_W-1:0]   audio_level;
    logic                flash_phase;

    home_computer_io_port_unit dut (.*);

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioural copy of the block's state
    // ------------------------------------------------------------------
    logic [KEY_COLS-1:0] key_matrix [KEY_ROWS];
    logic [BYTE_W-1:0]   joy_mask;
    logic [BORDER_W-1:0] border_q;
    logic                beep_q;
    logic [TIME_W-1:0]   edge_time_q;
    logic [FRAME_W-1:0]  frame_ctr;

    port_result_t expected_results [$];

    int unsigned fail_count      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned runs_seen       = 0;
    int unsigned frames_sent     = 0;
    int unsigned burst_left      = 0;
    int unsigned idle_cycles     = 0;

    // Close the beeper run from the last edge up to time t (already saturated).
    // Sample indices are rounded down; the end is clamped to the frame.
    function automatic port_result_t close_run(input port_result_t r,
                                               input logic [TIME_W-1:0] t);
        longint unsigned run_start;
        longint unsigned run_stop;
        run_start = edge_time_q;
        run_start = run_start * SAMPLES_FRAME / TSTATES_FRAME;
        run_stop  = t;
        run_stop  = run_stop * SAMPLES_FRAME / TSTATES_FRAME;
        if (run_stop > SAMPLES_FRAME)
            run_stop = SAMPLES_FRAME;
        // an edge time later than t gives an empty run: fields stay zero
        if (run_start < run_stop)
        begin
            r.audio_valid = 1'b1;
            r.audio_first = SAMPLE_W'(run_start);
            r.audio_end   = SAMPLE_W'(run_stop);
            r.audio_level = beep_q ? LEVEL_HIGH : LEVEL_LOW;
        end
        edge_time_q = t;
        return r;
    endfunction

    function automatic port_result_t predict_port_event(
        input logic [OP_W-1:0]   op,
        input logic [PORT_W-1:0] prt,
        input logic [BYTE_W-1:0] dat,
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  col,
        input logic              prs,
        input logic [TIME_W-1:0] ft
    );
        port_result_t        r;
        logic [KEY_COLS-1:0] acc;
        logic [TIME_W-1:0]   t_sat;
        int                  i;
        r           = '0;
        r.read_data = BYTE_ONES;    // anything but a read reports all ones
        case (op)
            OP_READ:
            begin
                if (!prt[0])
                begin
                    // rows selected by low high-address bits are ANDed
                    acc = ROW_IDLE;
                    for (i = 0; i < KEY_ROWS; i++)
                        if (!prt[8 + i])
                            acc &= key_matrix[i];
                    r.read_data = KEY_FILL | BYTE_W'(acc);
                end
                else if (prt[7:0] == JOY_PORT_LO)
                    r.read_data = joy_mask;
            end
            OP_WRITE:
            begin
                // odd ports are not decoded
                if (!prt[0])
                begin
                    border_q = dat[BORDER_W-1:0];
                    t_sat    = (ft > TIME_LIMIT) ? TIME_LIMIT : ft;
                    r        = close_run(r, t_sat);
                    beep_q   = dat[BEEP_BIT];
                end
            end
            OP_KEY:
            begin
                // columns past the matrix width are ignored
                if (col < KEY_COLS)
                    key_matrix[row][col] = !prs;
            end
            OP_JOY:
                joy_mask = dat;
            OP_FRAME:
            begin
                r           = close_run(r, TIME_LIMIT);
                edge_time_q = '0;
                frame_ctr   = frame_ctr + 1'b1;
            end
            default: ;
        endcase
        r.border_colour = border_q;
        r.flash_phase   = frame_ctr[FRAME_W-1];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Event sender: bursts of random length, random gaps between them.
    // Called just after a rising edge; returns just after the edge at
    // which the beat was taken.
    // ------------------------------------------------------------------
    task automatic send_event(
        input logic [OP_W-1:0]   op,
        input logic [PORT_W-1:0] prt,
        input logic [BYTE_W-1:0] dat,
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  col,
        input logic              prs,
        input logic [TIME_W-1:0] ft
    );
        int unsigned gap;
        if (burst_left == 0)
        begin
            // mostly short gaps, now and then a long back-to-back stretch
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        opcode      <= op;
        port        <= prt;
        data        <= dat;
        key_row     <= row;
        key_column  <= col;
        key_pressed <= prs;
        frame_time  <= ft;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_port_event(op, prt, dat, row, col, prs, ft));
        items_sent++;
    endtask

    // unused fields of each event get random filler
    task automatic send_read(input logic [PORT_W-1:0] prt);
        send_event(OP_READ, prt, BYTE_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                   1'($urandom), TIME_W'($urandom));
    endtask

    task automatic send_write(input logic [PORT_W-1:0] prt, input logic [BYTE_W-1:0] dat,
                              input logic [TIME_W-1:0] ft);
        send_event(OP_WRITE, prt, dat, ROW_W'($urandom), COL_W'($urandom),
                   1'($urandom), ft);
    endtask

    task automatic send_key(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                            input logic prs);
        send_event(OP_KEY, PORT_W'($urandom), BYTE_W'($urandom), row, col, prs,
                   TIME_W'($urandom));
    endtask

    task automatic send_joy(input logic [BYTE_W-1:0] dat);
        send_event(OP_JOY, PORT_W'($urandom), dat, ROW_W'($urandom), COL_W'($urandom),
                   1'($urandom), TIME_W'($urandom));
    endtask

    task automatic send_frame_end();
        send_event(OP_FRAME, PORT_W'($urandom), BYTE_W'($urandom), ROW_W'($urandom),
                   COL_W'($urandom), 1'($urandom), TIME_W'($urandom));
        frames_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result checker and output stall pattern
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    stall_mode_t stall_mode = STALL_NONE;
    int unsigned stall_left = 0;

    always @(posedge clk)
    begin
        port_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no event outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_data",     want.read_data,     read_data);
                check_field("border_colour", want.border_colour, border_colour);
                check_field("audio_valid",   want.audio_valid,   audio_valid);
                check_field("audio_first",   want.audio_first,   audio_first);
                check_field("audio_end",     want.audio_end,     audio_end);
                check_field("audio_level",   want.audio_level,   audio_level);
                check_field("flash_phase",   want.flash_phase,   flash_phase);
                results_checked++;
                if (want.audio_valid)
                    runs_seen++;
            end
        end
        // receiver: switch to a randomly chosen stall pattern when the current one runs out
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= ((stall_left % 8) < 5);
        endcase
    end

    // watchdog: too long without a beat on either side ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_reads();
        send_read(16'h001F);            // joystick latch clears on reset
        send_read(16'h0001);            // undecoded odd port
    endtask

    task automatic test_spare_opcodes();
        int op;
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_event(OP_W'(op), PORT_W'($urandom), BYTE_W'($urandom), ROW_W'($urandom),
                       COL_W'($urandom), 1'($urandom), TIME_W'($urandom));
    endtask

    task automatic test_key_matrix();
        send_key(3'd0, 3'd0, 1'b1);
        send_key(3'd7, 3'd4, 1'b1);
        send_key(3'd3, 3'd5, 1'b1);     // column out of range, no effect
        send_read(16'hFEFE);            // first row only
        send_read(16'h7FFE);            // last row only
        send_read(16'h0000);            // every row
        send_read(16'hFFFE);            // no row selected
        send_key(3'd0, 3'd0, 1'b0);
        send_key(3'd7, 3'd4, 1'b0);
        send_read(16'h00FE);
    endtask

    task automatic test_joystick_port();
        send_joy(8'hFF);
        send_read(16'h001F);
        send_joy(8'h5A);
        send_read(16'hFF1F);
    endtask

    task automatic test_border_and_beeper();
        send_write(16'h00FE, 8'h17, 17'd10000);
        send_write(16'h80FE, 8'h02, 17'd5000);     // earlier than last edge: empty
        send_write(16'h00FF, 8'h15, 17'd20000);    // odd port ignored
        send_write(16'hFFFE, 8'h10, 17'h1FFFF);    // time saturates to frame
        send_frame_end();                          // nothing left in the frame
        send_write(16'h0000, 8'h00, 17'd0);
        send_frame_end();                          // whole-frame run
    endtask

    // Mostly well-formed frames: writes with rising times, reads, key and
    // joystick traffic, closed by a frame end. The rest is raw noise.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned       counted;
        int unsigned       seq_len;
        int unsigned       pick;
        logic [TIME_W-1:0] cursor;
        logic [PORT_W-1:0] prt;
        logic [OP_W-1:0]   op;
        logic [COL_W-1:0]  col;
        counted = 0;
        while (counted < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                seq_len = $urandom_range(4, 24);
                cursor  = TIME_W'($urandom_range(0, 2000));
                repeat (seq_len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                    begin
                        if (cursor < TIME_LIMIT)
                            cursor = cursor + TIME_W'($urandom_range(0, 6000));
                        prt = PORT_W'($urandom) & ~PORT_W'(1);
                        send_write(prt, BYTE_W'($urandom), cursor);
                    end
                    else if (pick < 65)
                    begin
                        case ($urandom_range(0, 2))
                            0:       prt = PORT_W'($urandom) & ~PORT_W'(1);
                            1:       prt = {8'($urandom), JOY_PORT_LO};
                            default: prt = PORT_W'($urandom);
                        endcase
                        send_read(prt);
                    end
                    else if (pick < 88)
                        send_key(ROW_W'($urandom), COL_W'($urandom_range(0, KEY_COLS - 1)),
                                 1'($urandom));
                    else
                        send_joy(BYTE_W'($urandom));
                    counted++;
                end
                send_frame_end();
                counted++;
            end
            else
            begin
                repeat ($urandom_range(3, 12))
                begin
                    op  = OP_W'($urandom);
                    prt = PORT_W'($urandom);
                    col = COL_W'($urandom);
                    send_event(op, prt, BYTE_W'($urandom), ROW_W'($urandom), col,
                               1'($urandom), TIME_W'($urandom));
                    if (op == OP_FRAME)
                        frames_sent++;
                    // beats the block merely drops are not counted
                    if (!(op > OP_FRAME || (op == OP_WRITE && prt[0]) ||
                          (op == OP_KEY && col >= KEY_COLS)))
                        counted++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int r = 0; r < KEY_ROWS; r++)
            key_matrix[r] = ROW_IDLE;
        joy_mask    = '0;
        border_q    = BORDER_RESET;
        beep_q      = 1'b0;
        edge_time_q = '0;
        frame_ctr   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_reads();
        test_spare_opcodes();
        test_key_matrix();
        test_joystick_port();
        test_border_and_beeper();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;

        // let the pipe empty, then watch a little longer for stray beats
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d event beats sent, %0d results checked", items_sent,
                 results_checked);
        $display("tb: %0d beeper runs and %0d frame ends seen", runs_seen, frames_sent);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
